>>> src/pv2hp_pkg.sv
// Shared types and constants for the PROXY v2 header parser.
// Holds the signature table, status codes and the result record.
// No dependencies.
package pv2hp_pkg;

   localparam int LEN_W = 17;

   localparam logic [1:0] ST_MORE   = 2'd0;
   localparam logic [1:0] ST_REJECT = 2'd1;
   localparam logic [1:0] ST_ACCEPT = 2'd2;
   localparam logic [1:0] ST_IDLE   = 2'd3;

   localparam logic [1:0] FAM_NONE = 2'd0;
   localparam logic [1:0] FAM_IPV4 = 2'd1;
   localparam logic [1:0] FAM_IPV6 = 2'd2;

   localparam logic [3:0] VERSION_2  = 4'h2;
   localparam logic [3:0] CMD_LOCAL  = 4'h0;
   localparam logic [3:0] CMD_PROXY  = 4'h1;
   localparam logic [7:0] FP_TCP4    = 8'h11;
   localparam logic [7:0] FP_TCP6    = 8'h21;

   localparam logic [LEN_W-1:0] POS_SIG_END  = LEN_W'(12);
   localparam logic [LEN_W-1:0] POS_VER_CMD  = LEN_W'(12);
   localparam logic [LEN_W-1:0] POS_FAM      = LEN_W'(13);
   localparam logic [LEN_W-1:0] POS_LEN_HI   = LEN_W'(14);
   localparam logic [LEN_W-1:0] POS_LEN_LO   = LEN_W'(15);
   localparam logic [LEN_W-1:0] HDR_FIXED    = LEN_W'(16);
   localparam logic [LEN_W-1:0] POS_ADDR_END = LEN_W'(32);

   localparam logic [15:0] MIN_BODY_TCP4 = 16'd12;
   localparam logic [15:0] MIN_BODY_TCP6 = 16'd36;

   typedef struct packed {
      logic [63:0] addr_low;
      logic [63:0] addr_high;
      logic [1:0]  addr_family;
      logic        is_proxied;
      logic [8:0]  header_len;
      logic [1:0]  status;
   } result_type;

   function automatic logic [7:0] sig_byte(input logic [3:0] idx);
      logic [7:0] b;
      case (idx)
         4'd0:    b = 8'h0D;
         4'd1:    b = 8'h0A;
         4'd2:    b = 8'h0D;
         4'd3:    b = 8'h0A;
         4'd4:    b = 8'h00;
         4'd5:    b = 8'h0D;
         4'd6:    b = 8'h0A;
         4'd7:    b = 8'h51;
         4'd8:    b = 8'h55;
         4'd9:    b = 8'h49;
         4'd10:   b = 8'h54;
         4'd11:   b = 8'h0A;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

>>> src/pv2hp_core.sv
// Parse state and per-byte decision logic of the PROXY v2 header parser.
// Depends on pv2hp_pkg.
module pv2hp_core #(
   parameter int MAX_HEADER_BYTES = 256
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic [7:0]             data_byte,
   input  logic                   start_req,
   output pv2hp_pkg::result_type  result
);

   localparam int PW = $clog2(MAX_HEADER_BYTES);
   localparam logic [pv2hp_pkg::LEN_W-1:0] MAX_LEN =
      pv2hp_pkg::LEN_W'(MAX_HEADER_BYTES);

   logic          parsing_ff, parsing_in;
   logic [PW-1:0] pos_ff, pos_in;
   logic [7:0]    vc_ff, vc_in;
   logic [7:0]    fp_ff, fp_in;
   logic [15:0]   body_ff, body_in;
   logic [7:0]    src_ff [16];
   logic [7:0]    src_in [16];

   logic                          parsing_cur;
   logic [PW-1:0]                 pos_cur;
   logic [pv2hp_pkg::LEN_W-1:0]   pos_x;
   logic [15:0]                   body_cur;
   logic [pv2hp_pkg::LEN_W-1:0]   total;
   logic                          done;
   logic                          reject;

   always_comb begin
      parsing_cur = start_req | parsing_ff;
      pos_cur     = start_req ? '0 : pos_ff;
      pos_x       = pv2hp_pkg::LEN_W'(pos_cur);
      body_cur    = (pos_x == pv2hp_pkg::POS_LEN_LO) ? {body_ff[15:8], data_byte} : body_ff;
      total       = pv2hp_pkg::HDR_FIXED + pv2hp_pkg::LEN_W'(body_cur);

      parsing_in = parsing_ff;
      pos_in     = pos_ff;
      vc_in      = vc_ff;
      fp_in      = fp_ff;
      body_in    = body_ff;
      src_in     = src_ff;
      done       = 1'b0;
      reject     = 1'b0;
      result     = '0;
      result.status = pv2hp_pkg::ST_IDLE;

      if (parsing_cur) begin
         result.status = pv2hp_pkg::ST_MORE;
         if (pos_x < pv2hp_pkg::POS_SIG_END) begin
            if (data_byte != pv2hp_pkg::sig_byte(pos_x[3:0])) begin
               reject = 1'b1;
            end
         end else if (pos_x == pv2hp_pkg::POS_VER_CMD) begin
            vc_in = data_byte;
         end else if (pos_x == pv2hp_pkg::POS_FAM) begin
            fp_in = data_byte;
         end else if (pos_x == pv2hp_pkg::POS_LEN_HI) begin
            body_in = {data_byte, body_ff[7:0]};
         end else if (pos_x == pv2hp_pkg::POS_LEN_LO) begin
            body_in = body_cur;
            if (vc_ff[7:4] != pv2hp_pkg::VERSION_2 || vc_ff[3:0] > pv2hp_pkg::CMD_PROXY ||
                total > MAX_LEN) begin
               reject = 1'b1;
            end else if (body_cur == 16'd0) begin
               done = 1'b1;
            end
         end else begin
            if (pos_x < pv2hp_pkg::POS_ADDR_END) begin
               src_in[pos_x[3:0]] = data_byte;
            end
            if (pos_x + pv2hp_pkg::LEN_W'(1) >= total) begin
               done = 1'b1;
            end
         end

         if (done) begin
            if (vc_ff[3:0] == pv2hp_pkg::CMD_LOCAL) begin
               result.status     = pv2hp_pkg::ST_ACCEPT;
               result.header_len = total[8:0];
            end else if (fp_ff == pv2hp_pkg::FP_TCP4 && body_cur >= pv2hp_pkg::MIN_BODY_TCP4) begin
               result.status      = pv2hp_pkg::ST_ACCEPT;
               result.header_len  = total[8:0];
               result.is_proxied  = 1'b1;
               result.addr_family = pv2hp_pkg::FAM_IPV4;
               result.addr_low    = {32'd0, src_ff[0], src_ff[1], src_ff[2], src_ff[3]};
            end else if (fp_ff == pv2hp_pkg::FP_TCP6 && body_cur >= pv2hp_pkg::MIN_BODY_TCP6) begin
               result.status      = pv2hp_pkg::ST_ACCEPT;
               result.header_len  = total[8:0];
               result.is_proxied  = 1'b1;
               result.addr_family = pv2hp_pkg::FAM_IPV6;
               result.addr_high   = {src_ff[0], src_ff[1], src_ff[2], src_ff[3],
                                     src_ff[4], src_ff[5], src_ff[6], src_ff[7]};
               result.addr_low    = {src_ff[8], src_ff[9], src_ff[10], src_ff[11],
                                     src_ff[12], src_ff[13], src_ff[14], src_ff[15]};
            end else begin
               result.status = pv2hp_pkg::ST_REJECT;
            end
         end
         if (reject) begin
            result.status = pv2hp_pkg::ST_REJECT;
         end

         parsing_in = ~(done | reject);
         pos_in     = pos_cur + PW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         parsing_ff <= 1'b0;
         pos_ff     <= '0;
         vc_ff      <= '0;
         fp_ff      <= '0;
         body_ff    <= '0;
      end else if (accept) begin
         parsing_ff <= parsing_in;
         pos_ff     <= pos_in;
         vc_ff      <= vc_in;
         fp_ff      <= fp_in;
         body_ff    <= body_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         src_ff <= src_in;
      end
   end

endmodule

>>> src/pv2hp_out_stage.sv
// Result register between the parser and the response channel.
// Depends on pv2hp_pkg.
module pv2hp_out_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  pv2hp_pkg::result_type  in_data,
   output logic                   out_valid,
   input  logic                   out_ready,
   output pv2hp_pkg::result_type  out_data
);

   logic                  valid_ff;
   pv2hp_pkg::result_type data_ff;

   assign in_ready  = ~valid_ff | out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   // hold while the consumer stalls
   always_ff @(posedge clock) begin
      if (in_valid & in_ready) begin
         data_ff <= in_data;
      end
   end

endmodule

>>> src/proxy_v2_header_parser.sv
// Top level of the PROXY v2 header parser: parse core plus result register.
// Depends on pv2hp_pkg, pv2hp_core and pv2hp_out_stage.
//
// Takes one header byte per transaction and returns one result transaction
// for each, in the cycle after acceptance. The signature compare, field
// capture and final decision sit in a single layer of logic ahead of the
// result register, so a new byte is accepted on every clock while the
// response side takes results, and input stalls only while a result is held
// by a stalled response channel.
module proxy_v2_header_parser #(
   parameter int MAX_HEADER_BYTES = 256
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [7:0]    req_tdata,   // data_byte
   input  logic          req_tuser,   // start_req
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [143:0]  rsp_tdata    // status, header_len, is_proxied, addr_family,
                                      // addr_high, addr_low, zero pad
);

   pv2hp_pkg::result_type core_result;
   pv2hp_pkg::result_type out_result;
   logic                  req_accept;

   assign req_accept = req_tvalid & req_tready;

   pv2hp_core #(
      .MAX_HEADER_BYTES(MAX_HEADER_BYTES)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .data_byte (req_tdata),
      .start_req (req_tuser),
      .result    (core_result)
   );

   pv2hp_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (core_result),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_result)
   );

   assign rsp_tdata = {2'b00, out_result.addr_low, out_result.addr_high,
                       out_result.addr_family, out_result.is_proxied,
                       out_result.header_len, out_result.status};

endmodule

>>> src/pv2hp_checker.sv
// Port-level checks for the PROXY v2 header parser, bound to the top level.
// Depends on pv2hp_pkg and proxy_v2_header_parser.
module pv2hp_checker (
   input logic          clock,
   input logic          reset,
   input logic          req_tvalid,
   input logic          req_tready,
   input logic [7:0]    req_tdata,
   input logic          req_tuser,
   input logic          rsp_tvalid,
   input logic          rsp_tready,
   input logic [143:0]  rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   a_one_result: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("accepted byte produced no result");

   a_bad_first: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser && req_tdata != 8'h0D
      |=> rsp_tvalid && rsp_tdata[1:0] == pv2hp_pkg::ST_REJECT)
      else $error("bad first signature byte not rejected");

   a_zero_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] != pv2hp_pkg::ST_ACCEPT |-> rsp_tdata[143:2] == '0)
      else $error("non-accept result carries data");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input stalled without a held result");

endmodule

bind proxy_v2_header_parser pv2hp_checker u_checker (.*);
